### hdl/tanh_activation_unit_core_defines.svh
// Assertion macros shared by the tanh activation unit RTL.
`ifndef TANH_ACTIVATION_UNIT_CORE_DEFINES_SVH
`define TANH_ACTIVATION_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TAU_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tanh unit check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TAU_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tanh unit check failed");

`endif

### hdl/tau_pkg.sv
// Types and constants shared by the tanh activation unit modules.
`timescale 1ns / 1ps
`default_nettype none

package tau_pkg;

    typedef enum logic [1:0] {
        CMD_TANH   = 2'd0,
        CMD_TANH_D = 2'd1,
        CMD_RELU   = 2'd2,
        CMD_RELU_D = 2'd3
    } t_cmd;

    // Sideband that travels with every sample through the pipeline.
    typedef struct packed {
        logic               valid;
        t_cmd               cmd;
        logic signed [15:0] x;
        logic               last;
        logic               sat;
        logic               neg;
    } t_side;

    localparam logic [15:0] Q_ONE    = 16'd4096;
    localparam logic [15:0] SAT_CODE = 16'd20071;

    // Polynomial constants in Q16.
    localparam logic [24:0] A_K  = 25'(378)    << 16;
    localparam logic [30:0] B_K  = 31'(17325)  << 16;
    localparam logic [35:0] C_K  = 36'(135135) << 16;
    localparam logic [27:0] D1_K = 28'(3150)   << 16;
    localparam logic [33:0] D2_K = 34'(62370)  << 16;
    localparam logic [27:0] D1_COEF = 28'd28;

    localparam int NUM_W = 51;
    localparam int DEN_W = 38;
    localparam int QB    = 14;

endpackage

`default_nettype wire

### hdl/tau_poly.sv
// Five-stage numerator and denominator evaluation of the rational tanh form.
`timescale 1ns / 1ps
`default_nettype none

module tau_poly (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire tau_pkg::t_side                i_side,
    output tau_pkg::t_side                     o_side,
    output logic [tau_pkg::NUM_W-1:0]          o_num,
    output logic [tau_pkg::DEN_W-1:0]          o_den
);

    tau_pkg::t_side r1_side, r2_side, r3_side, r4_side, r5_side;
    tau_pkg::t_side n1_side;
    logic [14:0]    r1_m, r2_m, r3_m, r4_m;
    logic [15:0]    n_abs;
    logic [20:0]    r2_s, r3_s;
    logic [29:0]    r3_as;
    logic [32:0]    r3_ds;
    logic [35:0]    r4_bs;
    logic [37:0]    r4_d2s;
    logic [tau_pkg::NUM_W-1:0] r5_num;
    logic [tau_pkg::DEN_W-1:0] r5_den;

    logic [29:0] n_sq;
    logic [24:0] n_a;
    logic [27:0] n_d1;
    logic [45:0] n_as;
    logic [48:0] n_ds;
    logic [30:0] n_b;
    logic [33:0] n_d2;
    logic [51:0] n_bs;
    logic [54:0] n_d2s;
    logic [35:0] n_c;
    logic [tau_pkg::DEN_W-1:0] n_den;
    logic [tau_pkg::NUM_W-1:0] n_num;

    always_comb begin
        n_abs           = i_side.x[15] ? 16'(-i_side.x) : 16'(i_side.x);
        n1_side         = i_side;
        n1_side.neg     = i_side.x[15];
        n1_side.sat     = (n_abs >= tau_pkg::SAT_CODE);
        n_sq  = 30'(r1_m) * 30'(r1_m);
        n_a   = tau_pkg::A_K + 25'(r2_s);
        n_d1  = tau_pkg::D1_K + 28'(r2_s) * tau_pkg::D1_COEF;
        n_as  = 46'(n_a) * 46'(r2_s);
        n_ds  = 49'(n_d1) * 49'(r2_s);
        n_b   = tau_pkg::B_K + 31'(r3_as);
        n_d2  = tau_pkg::D2_K + 34'(r3_ds);
        n_bs  = 52'(n_b) * 52'(r3_s);
        n_d2s = 55'(n_d2) * 55'(r3_s);
        n_c   = tau_pkg::C_K + r4_bs;
        n_den = 38'(tau_pkg::C_K) + r4_d2s;
        n_num = 51'(r4_m) * 51'(n_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side.valid <= 1'b0;
            r2_side.valid <= 1'b0;
            r3_side.valid <= 1'b0;
            r4_side.valid <= 1'b0;
            r5_side.valid <= 1'b0;
        end else if (i_en) begin
            r1_side <= n1_side;
            r1_m    <= n1_side.sat ? 15'd0 : n_abs[14:0];
            r2_side <= r1_side;
            r2_m    <= r1_m;
            r2_s    <= n_sq[28:8];
            r3_side <= r2_side;
            r3_m    <= r2_m;
            r3_s    <= r2_s;
            r3_as   <= n_as[45:16];
            r3_ds   <= n_ds[48:16];
            r4_side <= r3_side;
            r4_m    <= r3_m;
            r4_bs   <= n_bs[51:16];
            r4_d2s  <= n_d2s[53:16];
            r5_side <= r4_side;
            r5_num  <= n_num;
            r5_den  <= n_den;
        end
    end

    assign o_side = r5_side;
    assign o_num  = r5_num;
    assign o_den  = r5_den;

endmodule

`default_nettype wire

### hdl/tau_div.sv
// Restoring divider, one quotient bit per pipeline stage, rounding to nearest.
`timescale 1ns / 1ps
`default_nettype none

module tau_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire tau_pkg::t_side                i_side,
    input  wire logic [tau_pkg::NUM_W-1:0]     i_num,
    input  wire logic [tau_pkg::DEN_W-1:0]     i_den,
    output tau_pkg::t_side                     o_side,
    output logic [tau_pkg::QB-1:0]             o_q
);

    localparam int QB = tau_pkg::QB;
    localparam int RW = tau_pkg::NUM_W + 1;

    tau_pkg::t_side            r_side [QB];
    logic [RW-1:0]             r_rem  [QB];
    logic [tau_pkg::DEN_W-1:0] r_den  [QB];
    logic [QB-1:0]             r_q    [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_stage
            tau_pkg::t_side            w_side;
            logic [RW-1:0]             w_rem;
            logic [tau_pkg::DEN_W-1:0] w_den;
            logic [QB-1:0]             w_q;
            logic [RW-1:0]             w_trial;

            if (k == 0) begin : g_first
                // The half-divisor bias turns truncation into round-to-nearest.
                assign w_side = i_side;
                assign w_rem  = RW'(i_num) + RW'(i_den >> 1);
                assign w_den  = i_den;
                assign w_q    = '0;
            end else begin : g_next
                assign w_side = r_side[k-1];
                assign w_rem  = r_rem[k-1];
                assign w_den  = r_den[k-1];
                assign w_q    = r_q[k-1];
            end

            assign w_trial = RW'(w_den) << (QB - 1 - k);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_side[k].valid <= 1'b0;
                end else if (i_en) begin
                    r_side[k] <= w_side;
                    r_den[k]  <= w_den;
                    if (w_rem >= w_trial) begin
                        r_rem[k]           <= w_rem - w_trial;
                        r_q[k]             <= w_q | (QB'(1) << (QB - 1 - k));
                    end else begin
                        r_rem[k]           <= w_rem;
                        r_q[k]             <= w_q;
                    end
                end
            end
        end
    endgenerate

    assign o_side = r_side[QB-1];
    assign o_q    = r_q[QB-1];

endmodule

`default_nettype wire

### hdl/tanh_activation_unit_core.sv
// Top level of the tanh activation unit: pipeline, result select and output register.
//
// Usage: samples enter on the s_axis stream; a transaction carries the Q4.12
// sample in tdata, the command in tuser (0 tanh, 1 tanh derivative, 2 ReLU,
// 3 ReLU derivative) and the end-of-vector mark in tlast. Results leave on the
// m_axis stream, one transaction per input, in order, with tlast copied.
// The pipeline is 20 register stages deep: five stages evaluate the rational
// polynomial, fourteen stages of the restoring divider each resolve one
// quotient bit, and one stage selects the result into the output register.
// Throughput is one transaction per cycle; the pipeline advances whenever
// the output register is empty or is being taken.
// When the receiver stalls, the whole pipeline holds and s_axis tready drops,
// so nothing is lost or repeated. Synchronous reset clears every valid bit;
// no result is pending afterwards.
//
`timescale 1ns / 1ps
`default_nettype none
`include "tanh_activation_unit_core_defines.svh"

module tanh_activation_unit_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // [15:0] x_value
    input  wire logic [1:0]  i_s_axis_tuser,   // [1:0] command
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [15:0] y_value
    output logic             o_m_axis_tlast
);

    logic                           w_en;
    tau_pkg::t_side                 w_in_side;
    tau_pkg::t_side                 w_poly_side;
    tau_pkg::t_side                 w_div_side;
    logic [tau_pkg::NUM_W-1:0]      w_num;
    logic [tau_pkg::DEN_W-1:0]      w_den;
    logic [tau_pkg::QB-1:0]         w_q;

    logic                           r_out_valid;
    logic signed [15:0]             r_out_y;
    logic                           r_out_last;
    tau_pkg::t_cmd                  r_out_cmd;

    logic [12:0]                    n_t;
    logic [25:0]                    n_tt;
    logic [15:0]                    n_deriv;
    logic signed [15:0]             n_y;

    logic                           w_chk_tanh;
    logic                           w_chk_deriv;
    logic                           w_chk_relud;

    // Every stage moves together; a held output register freezes them all.
    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_comb begin
        w_in_side       = '0;
        w_in_side.valid = i_s_axis_tvalid;
        w_in_side.cmd   = tau_pkg::t_cmd'(i_s_axis_tuser);
        w_in_side.x     = i_s_axis_tdata;
        w_in_side.last  = i_s_axis_tlast;
    end

    tau_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_in_side),
        .o_side  (w_poly_side),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    tau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_side  (w_poly_side),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_side  (w_div_side),
        .o_q     (w_q)
    );

    // Saturate the quotient to one and square it for the derivative.
    always_comb begin
        if (w_div_side.sat || (w_q > tau_pkg::QB'(tau_pkg::Q_ONE))) begin
            n_t = 13'(tau_pkg::Q_ONE);
        end else begin
            n_t = w_q[12:0];
        end
        n_tt = 26'(n_t) * 26'(n_t) + 26'd2048;
        if (w_div_side.x == 16'sd0) begin
            n_deriv = tau_pkg::Q_ONE;
        end else if (w_div_side.sat) begin
            n_deriv = 16'd0;
        end else begin
            n_deriv = tau_pkg::Q_ONE - 16'(n_tt[24:12]);
        end
        unique case (w_div_side.cmd)
            tau_pkg::CMD_TANH:   n_y = w_div_side.neg ? -$signed(16'(n_t)) : $signed(16'(n_t));
            tau_pkg::CMD_TANH_D: n_y = $signed(n_deriv);
            tau_pkg::CMD_RELU:   n_y = w_div_side.neg ? 16'sd0 : w_div_side.x;
            tau_pkg::CMD_RELU_D: n_y = w_div_side.neg ? 16'sd0 : $signed(tau_pkg::Q_ONE);
            default:             n_y = 16'sd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_side.valid;
            r_out_y     <= n_y;
            r_out_last  <= w_div_side.last;
            r_out_cmd   <= w_div_side.cmd;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_y;
    assign o_m_axis_tlast  = r_out_last;

    // Valid output qualified by its command, used by the range checks below.
    assign w_chk_tanh  = r_out_valid && (r_out_cmd == tau_pkg::CMD_TANH);
    assign w_chk_deriv = r_out_valid && (r_out_cmd == tau_pkg::CMD_TANH_D);
    assign w_chk_relud = r_out_valid && (r_out_cmd == tau_pkg::CMD_RELU_D);

    `TAU_ASSERT_IMPL(a_tanh_range, w_chk_tanh, (r_out_y <= 16'sd4096) && (r_out_y >= -16'sd4096))
    `TAU_ASSERT_IMPL(a_deriv_range, w_chk_deriv, (r_out_y <= 16'sd4096) && (r_out_y >= 16'sd0))
    `TAU_ASSERT_IMPL(a_relud_code, w_chk_relud, (r_out_y == 16'sd4096) || (r_out_y == 16'sd0))
    `TAU_ASSERT_NEXT(a_stall_hold, r_out_valid && !i_m_axis_tready, r_out_valid && $stable(r_out_y))

endmodule

`default_nettype wire
